// File: sv/spq_pkg.sv
// Types and constants shared by the sorted priority queue and its cells.
`default_nettype none
package spq_pkg;

  localparam int unsigned KEY_W  = 16;
  localparam int unsigned HELD_W = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    op_t  op;
    key_t key;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    key_t                removed_key;
    logic [HELD_W-1:0]   held;
  } out_item_t;

  // Broadcast from the control logic to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
    key_t key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/spq_cell.sv
// One storage cell of the sorted chain: holds a key and its valid bit.
`default_nettype none
module spq_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire spq_pkg::cell_ctrl_t   ctrl,
  input  wire spq_pkg::key_t         left_key,
  input  wire logic                  left_valid,
  input  wire logic                  left_place,
  input  wire spq_pkg::key_t         right_key,
  input  wire logic                  right_valid,
  output spq_pkg::key_t              key,
  output logic                       valid,
  output logic                       place
);
  import spq_pkg::*;

  key_t key_r, key_nxt;
  logic valid_r, valid_nxt;

  // A cell takes part in an insertion when it is empty or holds a larger key.
  assign place = !valid_r || (key_r > ctrl.key);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctrl.ins) begin
      valid_nxt = left_valid;
      if (place) begin
        key_nxt = left_place ? left_key : ctrl.key;
      end
    end else if (ctrl.rem) begin
      key_nxt   = right_key;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key   = key_r;
  assign valid = valid_r;

endmodule
`default_nettype wire

// File: sv/sorted_priority_queue.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// The result of a transaction is registered and offered in the cycle after acceptance.
// Throughput: one insert or remove per cycle; all cells compare against the key in parallel.
// The input is stalled only while a finished result waits on a stalled output.
// Reset clears every valid bit and the fill count, so the queue starts empty.
`default_nettype none
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire spq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output spq_pkg::out_item_t      out_data
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  key_t              cell_key   [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_place;
  cell_ctrl_t        ctrl;

  logic              accept;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              order_ok;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = cell_valid[DEPTH-1];
  assign empty    = !cell_valid[0];

  assign ctrl.ins = accept && (in_data.op == OP_INSERT) && !full;
  assign ctrl.rem = accept && (in_data.op == OP_REMOVE) && !empty;
  assign ctrl.key = in_data.key;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    key_t lk, rk;
    logic lv, lp, rv;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lv = 1'b1;
      assign lp = 1'b0;
    end else begin : g_mid
      assign lk = cell_key[i-1];
      assign lv = cell_valid[i-1];
      assign lp = cell_place[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rk = cell_key[i+1];
      assign rv = cell_valid[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_key    (lk),
      .left_valid  (lv),
      .left_place  (lp),
      .right_key   (rk),
      .right_valid (rv),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .place       (cell_place[i])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctrl.ins) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (ctrl.rem) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_data_nxt             = out_data_r;
    out_data_nxt.status      = ST_OK;
    out_data_nxt.removed_key = '0;
    out_data_nxt.held        = HELD_W'(fill_nxt);
    if (in_data.op == OP_INSERT) begin
      if (full) begin
        out_data_nxt.status = ST_OVERFLOW;
      end
    end else begin
      if (empty) begin
        out_data_nxt.status = ST_UNDERFLOW;
      end else begin
        out_data_nxt.removed_key = cell_key[0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    order_ok = 1'b1;
    for (int i = 1; i < DEPTH; i++) begin
      if (cell_valid[i] && (cell_key[i-1] > cell_key[i])) begin
        order_ok = 1'b0;
      end
    end
  end

  // The valid bits always form a contiguous run from the bottom cell.
  a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("cell valid bits are not contiguous");

  // The fill count agrees with the number of occupied cells.
  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == 32'(fill_r))
    else $error("fill count does not match occupied cells");

  // An accepted transaction always leaves a result on the output.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  // Neighbouring occupied cells stay in ascending order.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    order_ok)
    else $error("occupied cells are out of order");

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the sorted priority queue with directed and random transactions.
`default_nettype none
module testbench;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH    = 8;
  localparam int unsigned RANDOM_ITEMS   = 1250;
  localparam int unsigned QUIET_ITEMS    = 150;
  localparam int unsigned HOLD_OFF_AT    = 300;
  localparam int unsigned PAUSE_AT       = 600;
  localparam int unsigned HOLD_OFF_LEN   = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_LIMIT    = 500;
  localparam int unsigned SETTLE_CYCLES  = 8;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      in_fire;
  logic      out_fire;

  out_item_t   expected_results[$];
  key_t        model_slots[QUEUE_DEPTH];
  int unsigned model_fill   = 0;
  int unsigned mismatches   = 0;
  bit          quiet        = 1'b0;
  bit          hold_off_req = 1'b0;

  sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t predict_queue_op(input in_item_t item);
    out_item_t   res;
    int unsigned pos;
    res.status      = ST_OK;
    res.removed_key = '0;
    if (item.op == OP_INSERT) begin
      if (model_fill >= QUEUE_DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        pos = model_fill;
        while (pos > 0 && model_slots[pos-1] > item.key) begin
          model_slots[pos] = model_slots[pos-1];
          pos--;
        end
        model_slots[pos] = item.key;
        model_fill++;
      end
    end else if (model_fill == 0) begin
      res.status = ST_UNDERFLOW;
    end else begin
      res.removed_key = model_slots[0];
      for (int i = 1; i < model_fill; i++) model_slots[i-1] = model_slots[i];
      model_fill--;
    end
    res.held = HELD_W'(model_fill);
    return res;
  endfunction

  function automatic dir_row_t make_row(input op_t op, input key_t key, input logic typed,
                                        input status_t st, input key_t rk,
                                        input logic [HELD_W-1:0] held);
    dir_row_t r;
    r.stim.op          = op;
    r.stim.key         = key;
    r.typed            = typed;
    r.want.status      = st;
    r.want.removed_key = rk;
    r.want.held        = held;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic offer(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    dir_row_t    dir_rows[$];
    in_item_t    item;
    out_item_t   pred;
    int unsigned seg_left;
    int unsigned insert_weight;
    int unsigned drain;

    dir_rows.push_back(make_row(OP_REMOVE, 16'hFFFF, 1'b1, ST_UNDERFLOW, 16'h0000, 4'd0));
    dir_rows.push_back(make_row(OP_INSERT, 16'hFFFF, 1'b1, ST_OK, 16'h0000, 4'd1));
    dir_rows.push_back(make_row(OP_INSERT, 16'h0000, 1'b1, ST_OK, 16'h0000, 4'd2));
    dir_rows.push_back(make_row(OP_INSERT, 16'h8000, 1'b0, ST_OK, 16'h0000, 4'd0));
    dir_rows.push_back(make_row(OP_INSERT, 16'h8000, 1'b0, ST_OK, 16'h0000, 4'd0));
    dir_rows.push_back(make_row(OP_INSERT, 16'h0001, 1'b0, ST_OK, 16'h0000, 4'd0));
    dir_rows.push_back(make_row(OP_INSERT, 16'h7FFF, 1'b0, ST_OK, 16'h0000, 4'd0));
    dir_rows.push_back(make_row(OP_INSERT, 16'hFFFF, 1'b0, ST_OK, 16'h0000, 4'd0));
    dir_rows.push_back(make_row(OP_INSERT, 16'h1234, 1'b1, ST_OK, 16'h0000, 4'd8));
    dir_rows.push_back(make_row(OP_INSERT, 16'hAAAA, 1'b1, ST_OVERFLOW, 16'h0000, 4'd8));
    dir_rows.push_back(make_row(OP_INSERT, 16'h0000, 1'b1, ST_OVERFLOW, 16'h0000, 4'd8));
    dir_rows.push_back(make_row(OP_REMOVE, 16'hFFFF, 1'b1, ST_OK, 16'h0000, 4'd7));
    for (int i = 0; i < 7; i++) begin
      dir_rows.push_back(make_row(OP_REMOVE, key_t'(16'h5A5A ^ i), 1'b0,
                                  ST_OK, 16'h0000, 4'd0));
    end
    dir_rows.push_back(make_row(OP_REMOVE, 16'h0000, 1'b1, ST_UNDERFLOW, 16'h0000, 4'd0));
    dir_rows.push_back(make_row(OP_INSERT, 16'h5555, 1'b0, ST_OK, 16'h0000, 4'd0));
    dir_rows.push_back(make_row(OP_REMOVE, 16'h0000, 1'b0, ST_OK, 16'h0000, 4'd0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].stim);
      pred = predict_queue_op(dir_rows[i].stim);
      expected_results.push_back(dir_rows[i].typed ? dir_rows[i].want : pred);
      maybe_idle();
    end

    // Let the directed transactions drain before the random part starts.
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    seg_left      = 0;
    insert_weight = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_OFF_AT) hold_off_req = 1'b1;
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0: begin
            insert_weight = 75;
          end
          1: begin
            insert_weight = 25;
          end
          default: begin
            insert_weight = 50;
          end
        endcase
      end
      seg_left--;
      item.op  = ($urandom_range(0, 99) < insert_weight) ? OP_INSERT : OP_REMOVE;
      item.key = ($urandom_range(0, 3) == 0) ? key_t'($urandom_range(0, 7)) : key_t'($urandom);
      offer(item);
      expected_results.push_back(predict_queue_op(item));
      maybe_idle();
    end
    in_valid <= 1'b0;

    drain = 0;
    while (expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", expected_results.size(), 0);
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_fire) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status != want.status) begin
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        end
        if (out_data.removed_key != want.removed_key) begin
          report_mismatch("removed_key", 32'(out_data.removed_key),
                          32'(want.removed_key));
        end
        if (out_data.held != want.held) begin
          report_mismatch("held", 32'(out_data.held), 32'(want.held));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire) idle = 0;
      else idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
